### hdl/awrt_pkg.sv
// Shared types and constants for the acknowledgment-wait retransmit table.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package awrt_pkg;

   localparam int STAMP_W   = 32;
   localparam int TAG_W     = 16;
   localparam int RETRY_W   = 3;
   localparam int LIMIT_W   = 3;
   localparam int AFTER_W   = 8;
   localparam int CSR_DW    = 32;
   localparam int CSR_AW    = 3;
   localparam int REQ_DW    = 80;
   localparam int RSP_DW    = 56;

   localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

   localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET  = 3'd2;
   localparam logic [AFTER_W-1:0] RESEND_AFTER_RESET = 8'd1;

   // Register index, taken from the word address.
   typedef enum logic {
      CSR_RETRY_LIMIT  = 1'b0,
      CSR_RESEND_AFTER = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_SCAN   = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      EV_ACCEPTED = 3'd0,
      EV_FULL     = 3'd1,
      EV_ARRIVED  = 3'd2,
      EV_LOST     = 3'd3,
      EV_RESEND   = 3'd4
   } event_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } engine_state_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] now_time;
   } cmd_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   tag;
      logic [RETRY_W-1:0] retries;
   } entry_type;

   typedef struct packed {
      event_kind_type     kind;
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   tag;
      logic [RETRY_W-1:0] retries;
   } event_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] retry_limit;
      logic [AFTER_W-1:0] resend_after;
   } csr_type;

endpackage

`default_nettype wire

### hdl/awrt_csr.sv
// Configuration registers of the retransmit table behind an APB-style port.
// Depends on awrt_pkg.
`default_nettype none

module awrt_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [awrt_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [awrt_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [awrt_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                              csr_pready,
   output awrt_pkg::csr_type                 cfg
);

   logic [awrt_pkg::LIMIT_W-1:0] retry_limit_ff, retry_limit_in;
   logic [awrt_pkg::AFTER_W-1:0] resend_after_ff, resend_after_in;
   awrt_pkg::csr_index_type      index;
   logic                         write_en;

   assign csr_pready = 1'b1;
   assign index      = awrt_pkg::csr_index_type'(csr_paddr[2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      retry_limit_in  = retry_limit_ff;
      resend_after_in = resend_after_ff;
      if (write_en) begin
         unique case (index)
            awrt_pkg::CSR_RETRY_LIMIT:
               retry_limit_in = csr_pwdata[awrt_pkg::LIMIT_W-1:0];
            awrt_pkg::CSR_RESEND_AFTER:
               resend_after_in = csr_pwdata[awrt_pkg::AFTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         awrt_pkg::CSR_RETRY_LIMIT:
            csr_prdata = awrt_pkg::CSR_DW'(retry_limit_ff);
         awrt_pkg::CSR_RESEND_AFTER:
            csr_prdata = awrt_pkg::CSR_DW'(resend_after_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff  <= awrt_pkg::RETRY_LIMIT_RESET;
         resend_after_ff <= awrt_pkg::RESEND_AFTER_RESET;
      end else begin
         retry_limit_ff  <= retry_limit_in;
         resend_after_ff <= resend_after_in;
      end
   end

   assign cfg.retry_limit  = retry_limit_ff;
   assign cfg.resend_after = resend_after_ff;

endmodule

`default_nettype wire

### hdl/awrt_cmd_queue.sv
// Front end: accepts request words, decodes them into commands and holds
// them in a two-entry queue for the table engine. Depends on awrt_pkg.
`default_nettype none

module awrt_cmd_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [awrt_pkg::REQ_DW-1:0] req_tdata,
   input  wire logic                        req_tuser,
   output logic                             cmd_valid,
   output awrt_pkg::cmd_type                cmd,
   input  wire logic                        cmd_pop
);

   awrt_pkg::cmd_type slot_ff [2];
   awrt_pkg::cmd_type push_cmd;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        level_ff, level_in;
   logic              push;
   logic              pop;

   assign req_tready = (level_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (level_ff != 2'd0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      push_cmd.kind     = awrt_pkg::req_kind_type'(req_tuser);
      push_cmd.stamp    = req_tdata[31:0];
      push_cmd.tag      = req_tdata[47:32];
      push_cmd.now_time = req_tdata[79:48];
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 2'd1;
      end else if (pop && !push) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### hdl/awrt_engine.sv
// Back end: the ordered entry table, the scan sequencer and the result
// register. Entries circulate through a shift line whose head is examined.
// Depends on awrt_pkg.
`default_nettype none

module awrt_engine #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  awrt_pkg::csr_type                 cfg,
   input  wire logic                         cmd_valid,
   input  awrt_pkg::cmd_type                 cmd,
   output logic                              cmd_pop,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [awrt_pkg::RSP_DW-1:0]  rsp_tdata,
   output logic      [2:0]                   rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_ROTATE,
      OP_REMOVE
   } table_op_type;

   awrt_pkg::entry_type ent_ff [TABLE_DEPTH];
   awrt_pkg::entry_type ent_in [TABLE_DEPTH];
   awrt_pkg::entry_type head;
   awrt_pkg::entry_type head_upd;
   awrt_pkg::entry_type new_ent;

   awrt_pkg::engine_state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic               stopped_ff, stopped_in;
   logic [awrt_pkg::STAMP_W-1:0] scan_stamp_ff, scan_stamp_in;
   logic [awrt_pkg::STAMP_W-1:0] scan_now_ff, scan_now_in;
   awrt_pkg::event_type held_ff, held_in;
   logic                held_valid_ff, held_valid_in;
   awrt_pkg::event_type out_ff, out_in;
   logic                out_last_ff, out_last_in;
   logic                out_valid_ff, out_valid_in;

   table_op_type        op;
   logic                out_free;
   logic                out_push;
   awrt_pkg::event_type push_evt;
   logic                push_last;
   logic                hit_match, hit_lost, hit_resend, hit_any;
   logic [33:0]         age;
   logic [awrt_pkg::RETRY_W-1:0] bumped;
   awrt_pkg::event_type scan_evt;
   logic [CNT_W-1:0]    last_pos;

   assign head     = ent_ff[0];
   assign out_free = !out_valid_ff || rsp_tready;
   assign last_pos = count_ff - CNT_W'(1);

   // Age is a true signed difference: a stamp ahead of now_time is never due.
   assign age        = {2'b00, scan_now_ff} - {2'b00, head.stamp};
   assign hit_match  = (head.stamp == scan_stamp_ff);
   assign hit_lost   = (head.retries > cfg.retry_limit);
   assign hit_resend = ($signed(age) > $signed({26'd0, cfg.resend_after}));
   assign hit_any    = hit_match || hit_lost || hit_resend;
   assign bumped     = (head.retries == awrt_pkg::RETRY_MAX) ? head.retries
                                                             : head.retries + 3'd1;

   // Once the scan has stopped, entries pass through without any change.
   always_comb begin
      head_upd = head;
      if (!stopped_ff && !hit_match && !hit_lost && hit_resend) begin
         head_upd.retries = bumped;
      end
   end

   always_comb begin
      scan_evt.stamp   = head.stamp;
      scan_evt.tag     = head.tag;
      scan_evt.retries = head.retries;
      if (hit_match) begin
         scan_evt.kind = awrt_pkg::EV_ARRIVED;
      end else if (hit_lost) begin
         scan_evt.kind = awrt_pkg::EV_LOST;
      end else begin
         scan_evt.kind    = awrt_pkg::EV_RESEND;
         scan_evt.retries = bumped;
      end
   end

   always_comb begin
      new_ent.stamp   = cmd.stamp;
      new_ent.tag     = cmd.tag;
      new_ent.retries = '0;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      stopped_in    = stopped_ff;
      scan_stamp_in = scan_stamp_ff;
      scan_now_in   = scan_now_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      op            = OP_NONE;
      cmd_pop       = 1'b0;
      out_push      = 1'b0;
      push_evt      = held_ff;
      push_last     = 1'b0;

      unique case (state_ff)
         awrt_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == awrt_pkg::REQ_SCAN) begin
                  cmd_pop       = 1'b1;
                  scan_stamp_in = cmd.stamp;
                  scan_now_in   = cmd.now_time;
                  rem_in        = count_ff;
                  stopped_in    = 1'b0;
                  state_in      = awrt_pkg::ST_SCAN;
               end else if (out_free) begin
                  cmd_pop        = 1'b1;
                  out_push       = 1'b1;
                  push_last      = 1'b1;
                  push_evt.stamp   = cmd.stamp;
                  push_evt.tag     = cmd.tag;
                  push_evt.retries = '0;
                  if (count_ff == FULL_COUNT) begin
                     push_evt.kind = awrt_pkg::EV_FULL;
                  end else begin
                     push_evt.kind = awrt_pkg::EV_ACCEPTED;
                     op            = OP_INSERT;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         awrt_pkg::ST_SCAN: begin
            if (rem_ff == '0) begin
               state_in = held_valid_ff ? awrt_pkg::ST_FLUSH : awrt_pkg::ST_IDLE;
            end else if (stopped_ff || !hit_any) begin
               // Entries past the acknowledged one, and entries with nothing to report, only move back into order.
               op     = OP_ROTATE;
               rem_in = rem_ff - CNT_W'(1);
            end else if (!held_valid_ff || out_free) begin
               // The previous event goes out once it is known not to be the last.
               out_push      = held_valid_ff;
               held_in       = scan_evt;
               held_valid_in = 1'b1;
               rem_in        = rem_ff - CNT_W'(1);
               if (hit_match || hit_lost) begin
                  op       = OP_REMOVE;
                  count_in = count_ff - CNT_W'(1);
                  stopped_in = hit_match;
               end else begin
                  op = OP_ROTATE;
               end
            end
         end
         awrt_pkg::ST_FLUSH: begin
            if (out_free) begin
               out_push      = 1'b1;
               push_last     = 1'b1;
               held_valid_in = 1'b0;
               state_in      = awrt_pkg::ST_IDLE;
            end
         end
         default: state_in = awrt_pkg::ST_IDLE;
      endcase
   end

   // Each position picks its next value from itself, its successor, the head or the new entry.
   always_comb begin
      int src;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         src       = (k + 1 < TABLE_DEPTH) ? k + 1 : k;
         ent_in[k] = ent_ff[k];
         case (op)
            OP_INSERT: begin
               if (CNT_W'(k) == count_ff) begin
                  ent_in[k] = new_ent;
               end
            end
            OP_ROTATE: begin
               if (CNT_W'(k) == last_pos) begin
                  ent_in[k] = head_upd;
               end else if (CNT_W'(k) < last_pos) begin
                  ent_in[k] = ent_ff[src];
               end
            end
            OP_REMOVE: begin
               if (CNT_W'(k) < last_pos) begin
                  ent_in[k] = ent_ff[src];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      if (out_push) begin
         out_in       = push_evt;
         out_last_in  = push_last;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= awrt_pkg::ST_IDLE;
         count_ff      <= '0;
         rem_ff        <= '0;
         stopped_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rem_ff        <= rem_in;
         stopped_ff    <= stopped_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_stamp_ff <= scan_stamp_in;
      scan_now_ff   <= scan_now_in;
      held_ff       <= held_in;
      out_ff        <= out_in;
      out_last_ff   <= out_last_in;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         ent_ff[k] <= ent_in[k];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.retries, out_ff.tag, out_ff.stamp};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

### hdl/ack_wait_retransmit_table.sv
// A table of sent messages that await acknowledgment. An insert word is handled
// by the table engine and gives one result. An acknowledgment scan walks the
// stored entries oldest first, one entry a cycle through the head of a
// circulating shift line, while the result side does not stall it. A two-word
// command queue in front lets requests be accepted while a scan runs. Results
// carry event_kind in tuser and mark the final result of a request with tlast;
// a scan that finds nothing gives no result.
// Depends on awrt_pkg, awrt_csr, awrt_cmd_queue and awrt_engine.
`default_nettype none

module ack_wait_retransmit_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // req_tdata: stamp[31:0], payload_tag[47:32], now_time[79:48]
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [awrt_pkg::REQ_DW-1:0]  req_tdata,
   // req_tuser: req_type[0]
   input  wire logic                         req_tuser,
   // rsp_tdata: event_stamp[31:0], event_tag[47:32], event_retries[50:48]
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [awrt_pkg::RSP_DW-1:0]  rsp_tdata,
   // rsp_tuser: event_kind[2:0]
   output logic      [2:0]                   rsp_tuser,
   output logic                              rsp_tlast,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [awrt_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [awrt_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [awrt_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                              csr_pready
);

   awrt_pkg::csr_type cfg;
   awrt_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;

   awrt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   awrt_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   awrt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
